// File: design/fess_pkg.sv
// ----------------------------------------------------------------------------
// fess_pkg: shared definitions for the forward-Euler state-space stepper
// Field widths, interface widths and the datapath control bundle.
// ----------------------------------------------------------------------------
package fess_pkg;

  // Default number of state variables the storage is sized for.
  localparam int ORDER_MAX_DEF = 4;

  // Fixed field widths.
  localparam int DATA_W    = 32;
  localparam int DT_W      = 31;
  localparam int ORDER_W   = 3;
  localparam int IDX_W     = 2;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 72;

  // Operation of the shared multiplier in a given cycle.
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_MAC  = 2'd1,
    MUL_HI   = 2'd2,
    MUL_LO   = 2'd3
  } mul_op_t;

  // Control from the sequencer to the arithmetic datapath.
  typedef struct packed {
    mul_op_t mul_op;
    logic    b_term;
    logic    acc_clear;
    logic    take_x;
    logic    clamp;
  } fess_ctrl_t;

endpackage

// File: design/fess_datapath.sv
// ----------------------------------------------------------------------------
// fess_datapath: shared multiplier, accumulator and state update
// One signed multiplier serves the row products and the time-step scaling.
// ----------------------------------------------------------------------------
module fess_datapath #(
  parameter int ORDER_MAX = fess_pkg::ORDER_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fess_pkg::fess_ctrl_t                ctrl,
  input  logic signed [fess_pkg::DATA_W-1:0]  coef,
  input  logic signed [fess_pkg::DATA_W-1:0]  x_val,
  input  logic signed [fess_pkg::DATA_W-1:0]  input_level,
  input  logic        [fess_pkg::DT_W-1:0]    time_step,
  output logic signed [fess_pkg::DATA_W-1:0]  new_value
);
  import fess_pkg::*;

  // Room for ORDER_MAX + 1 exact 64-bit products.
  localparam int ACC_W  = 64 + $clog2(ORDER_MAX + 1);
  localparam int SL_W   = 16;
  localparam int MA_W   = 34;
  localparam int MB_W   = 33;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W + 1;

  // Past this bound the new state saturates for any nonzero step size.
  localparam logic signed [ACC_W-1:0] S_LIM = ACC_W'(64'sd281474976710656);
  localparam logic signed [SUM_W-1:0] R_MAX = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] R_MIN = -R_MAX - SUM_W'(1);

  mul_op_t                   op_q;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  phi;
  logic signed [PROD_W-1:0]  delta;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   s_full;
  logic signed [ACC_W-1:0]   s_clamp;
  logic signed [MA_W-1:0]    sh;
  logic        [SL_W-1:0]    sl;
  logic signed [DATA_W-1:0]  xi;
  logic signed [SUM_W-1:0]   r_sum;

  // Floor of the exact sum in Q16.16, limited to the useful range.
  assign s_full = acc >>> SL_W;

  always_comb begin
    if (s_full > S_LIM) begin
      s_clamp = S_LIM;
    end else if (s_full < -S_LIM) begin
      s_clamp = -S_LIM;
    end else begin
      s_clamp = s_full;
    end
  end

  always_comb begin
    case (ctrl.mul_op)
      MUL_MAC: begin
        mul_a = MA_W'(coef);
        mul_b = ctrl.b_term ? MB_W'(input_level) : MB_W'(x_val);
      end
      MUL_HI: begin
        mul_a = sh;
        mul_b = MB_W'(time_step);
      end
      MUL_LO: begin
        mul_a = MA_W'(sl);
        mul_b = MB_W'(time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= MUL_NONE;
    end else begin
      op_q <= ctrl.mul_op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctrl.acc_clear) begin
      acc <= '0;
    end else if (op_q == MUL_MAC) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctrl.clamp) begin
      sh <= s_clamp[SL_W +: MA_W];
      sl <= s_clamp[SL_W-1:0];
    end
    if (op_q == MUL_HI) begin
      phi <= prod;
    end
    // The low part is never negative, so its floor is a plain shift.
    if (op_q == MUL_LO) begin
      delta <= phi + (prod >>> SL_W);
    end
    if (ctrl.take_x) begin
      xi <= x_val;
    end
  end

  assign r_sum = SUM_W'(xi) + SUM_W'(delta);

  always_comb begin
    if (r_sum > R_MAX) begin
      new_value = 32'sh7fff_ffff;
    end else if (r_sum < R_MIN) begin
      new_value = 32'sh8000_0000;
    end else begin
      new_value = r_sum[DATA_W-1:0];
    end
  end

endmodule

// File: design/forward_euler_state_space_step.sv
// ----------------------------------------------------------------------------
// forward_euler_state_space_step: forward-Euler stepper for x' = A x + b u
// Holds A, b and the state x in on-chip memories and advances x one step
// per step transaction, reporting the state before each update.
// ----------------------------------------------------------------------------
// Each input transaction carries a command in tuser. A write of A[row][col] or
// b[row] goes to the coefficient memory; rows or columns at or beyond ORDER_MAX
// are dropped, as is the unused command. A step transaction first sends one
// output transaction per active state variable (its index, its value before
// the update and the step count, with tlast on the final one) and then
// computes x[i] + floor(floor(sum/2^16) * dt / 2^16) with 32-bit saturation,
// where sum is the exact sum of A[i][k]*x[k] and b[i]*u. Output stalls during
// the report lengthen the step. The one shared multiplier takes one product per
// cycle behind the registered memory read; for every row the products are followed
// by the clamp, two scaling products, the sum and the saturating write. The state
// memory has two banks: a step reads one and writes the other, then swaps, so
// no forwarding is needed; rows past the active order are copied across.
// Configuration and new input transactions are taken only while the block is
// idle. Every memory entry carries a valid bit cleared by reset and reads as
// zero until written, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module forward_euler_state_space_step #(
  parameter int ORDER_MAX = fess_pkg::ORDER_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fess_pkg::S_TDATA_W-1:0]      s_tdata,   // row[1:0], col[3:2], value[35:4]
  input  logic [fess_pkg::CMD_W-1:0]          s_tuser,   // cmd[1:0]
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fess_pkg::M_TDATA_W-1:0]      m_tdata,   // state_index[1:0],
                                                         // state_value[33:2],
                                                         // step_number[65:34]
  output logic                                m_tlast,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fess_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fess_pkg::DATA_W-1:0]         cfg_data
);
  import fess_pkg::*;

  localparam int CW       = $clog2(ORDER_MAX + 1);
  localparam int CA_DEPTH = ORDER_MAX * (ORDER_MAX + 1);
  localparam int CAW      = (CA_DEPTH > 1) ? $clog2(CA_DEPTH) : 1;
  localparam int XDEPTH   = 2 * ORDER_MAX;
  localparam int XAW      = $clog2(XDEPTH);
  localparam int OUT_PAD  = M_TDATA_W - IDX_W - 2 * DATA_W;

  // Commands carried in tuser.
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_A = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_B = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_U     = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RST = 3'd1;
  localparam logic [DT_W-1:0]    DT_RST    = 31'd66;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0_0000_0000_0001,
    S_REP_RD  = 13'b0_0000_0000_0010,
    S_REP_OUT = 13'b0_0000_0000_0100,
    S_MAC     = 13'b0_0000_0000_1000,
    S_DRAIN0  = 13'b0_0000_0001_0000,
    S_DRAIN1  = 13'b0_0000_0010_0000,
    S_CLAMP   = 13'b0_0000_0100_0000,
    S_HI      = 13'b0_0000_1000_0000,
    S_LO      = 13'b0_0001_0000_0000,
    S_SUM     = 13'b0_0010_0000_0000,
    S_SAT     = 13'b0_0100_0000_0000,
    S_COPY_RD = 13'b0_1000_0000_0000,
    S_COPY_WR = 13'b1_0000_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [ORDER_W-1:0]       order;
  logic [DT_W-1:0]          time_step;
  logic signed [DATA_W-1:0] input_level;

  // Sequencer registers.
  logic [CW-1:0] n_act;
  logic [CW-1:0] n_sel;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic          bank;
  logic [31:0]   step_count;
  logic          rd_vld;
  logic          rd_b;
  logic          rd_self;
  logic          last_i;

  // Input fields.
  logic [1:0]               in_row;
  logic [1:0]               in_col;
  logic signed [DATA_W-1:0] in_value;
  logic                     s_fire;
  logic                     cfg_fire;
  logic                     row_ok;
  logic                     col_ok;

  // Coefficient memory: row r holds A[r][0..ORDER_MAX-1], then b[r].
  logic [DATA_W-1:0]        coef_mem [CA_DEPTH];
  logic [CA_DEPTH-1:0]      coef_ok;
  logic                     coef_ok_q;
  logic [DATA_W-1:0]        coef_q;
  logic signed [DATA_W-1:0] coef_rd;
  logic                     coef_we;
  logic [CAW-1:0]           coef_waddr;
  logic [CAW-1:0]           coef_raddr;

  // State memory: two banks of ORDER_MAX entries.
  logic [DATA_W-1:0]        x_mem [XDEPTH];
  logic [XDEPTH-1:0]        x_ok;
  logic                     x_ok_q;
  logic [DATA_W-1:0]        x_q;
  logic signed [DATA_W-1:0] x_rd;
  logic                     x_we;
  logic [XAW-1:0]           x_waddr;
  logic [XAW-1:0]           x_raddr;
  logic [CW-1:0]            x_ridx;
  logic [DATA_W-1:0]        x_wdata;

  // Output register.
  logic                     out_load;
  logic [IDX_W-1:0]         out_index;
  logic [DATA_W-1:0]        out_value;
  logic [31:0]              out_step;
  logic                     out_last;

  fess_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] new_value;

  assign in_row   = s_tdata[1:0];
  assign in_col   = s_tdata[3:2];
  assign in_value = s_tdata[4 +: DATA_W];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      order       <= ORDER_RST;
      time_step   <= DT_RST;
      input_level <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_ORDER: order       <= cfg_data[ORDER_W-1:0];
        CFG_DT:    time_step   <= cfg_data[DT_W-1:0];
        CFG_U:     input_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Order zero behaves as one; orders past the storage clamp to it.
  always_comb begin
    if (order == '0) begin
      n_sel = CW'(1);
    end else if (32'(order) > ORDER_MAX) begin
      n_sel = CW'(ORDER_MAX);
    end else begin
      n_sel = CW'(order);
    end
  end

  // Coefficient writes from the input stream.
  assign row_ok  = (32'(in_row) < ORDER_MAX);
  assign col_ok  = (32'(in_col) < ORDER_MAX);
  assign coef_we = s_fire && (((s_tuser == CMD_WR_A) && row_ok && col_ok) ||
                              ((s_tuser == CMD_WR_B) && row_ok));
  assign coef_waddr = CAW'(32'(in_row) * (ORDER_MAX + 1) +
                           ((s_tuser == CMD_WR_B) ? ORDER_MAX : 32'(in_col)));

  // During the row loop, k equal to the order selects the b entry.
  assign coef_raddr = CAW'(32'(i) * (ORDER_MAX + 1) +
                           ((k == n_act) ? ORDER_MAX : 32'(k)));

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_value;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ok   <= '0;
      coef_ok_q <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_ok[coef_waddr] <= 1'b1;
      end
      coef_ok_q <= coef_ok[coef_raddr];
    end
  end

  assign coef_rd = coef_ok_q ? coef_q : '0;

  // The row loop walks k over the old bank; elsewhere the row counter picks
  // the entry. The b-term cycle reads entry zero, and its data goes unused.
  always_comb begin
    if (state == S_MAC) begin
      x_ridx = (k == n_act) ? '0 : k;
    end else begin
      x_ridx = i;
    end
  end

  assign x_raddr = XAW'(32'(bank) * ORDER_MAX + 32'(x_ridx));
  assign x_waddr = XAW'(32'(!bank) * ORDER_MAX + 32'(i));
  assign x_we    = (state == S_SAT) || (state == S_COPY_WR);
  assign x_wdata = (state == S_SAT) ? new_value : x_rd;

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[x_waddr] <= x_wdata;
    end
    x_q <= x_mem[x_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_ok   <= '0;
      x_ok_q <= 1'b0;
    end else begin
      if (x_we) begin
        x_ok[x_waddr] <= 1'b1;
      end
      x_ok_q <= x_ok[x_raddr];
    end
  end

  assign x_rd = x_ok_q ? x_q : '0;

  assign last_i = (i == n_act - CW'(1));

  // Main sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire && (s_tuser == CMD_STEP)) begin
          state_next = S_REP_RD;
        end
      end
      S_REP_RD:  state_next = S_REP_OUT;
      S_REP_OUT: begin
        if (out_load) begin
          state_next = last_i ? S_MAC : S_REP_RD;
        end
      end
      S_MAC: begin
        if (k == n_act) begin
          state_next = S_DRAIN0;
        end
      end
      S_DRAIN0: state_next = S_DRAIN1;
      S_DRAIN1: state_next = S_CLAMP;
      S_CLAMP:  state_next = S_HI;
      S_HI:     state_next = S_LO;
      S_LO:     state_next = S_SUM;
      S_SUM:    state_next = S_SAT;
      S_SAT: begin
        if (!last_i) begin
          state_next = S_MAC;
        end else if (32'(n_act) < ORDER_MAX) begin
          state_next = S_COPY_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: begin
        state_next = (32'(i) == ORDER_MAX - 1) ? S_IDLE : S_COPY_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      n_act      <= CW'(1);
      i          <= '0;
      k          <= '0;
      bank       <= 1'b0;
      step_count <= '0;
      rd_vld     <= 1'b0;
      rd_b       <= 1'b0;
      rd_self    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= (state == S_MAC);
      rd_b    <= (k == n_act);
      rd_self <= (k == i);
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            n_act <= n_sel;
            i     <= '0;
            k     <= '0;
          end
        end
        S_REP_OUT: begin
          if (out_load) begin
            i <= last_i ? '0 : i + CW'(1);
          end
        end
        S_MAC: k <= k + CW'(1);
        S_SAT: begin
          k <= '0;
          i <= i + CW'(1);
          // With every row active there is nothing to copy: the step ends.
          if (last_i && (32'(n_act) >= ORDER_MAX)) begin
            bank       <= !bank;
            step_count <= step_count + 32'd1;
          end
        end
        S_COPY_WR: begin
          i <= i + CW'(1);
          if (32'(i) == ORDER_MAX - 1) begin
            bank       <= !bank;
            step_count <= step_count + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath control. Memory data arrives in the cycle after each issue.
  always_comb begin
    if (rd_vld) begin
      ctrl.mul_op = MUL_MAC;
    end else if (state == S_HI) begin
      ctrl.mul_op = MUL_HI;
    end else if (state == S_LO) begin
      ctrl.mul_op = MUL_LO;
    end else begin
      ctrl.mul_op = MUL_NONE;
    end
    ctrl.b_term    = rd_b;
    ctrl.acc_clear = (state == S_MAC) && (k == '0);
    ctrl.take_x    = rd_vld && rd_self && !rd_b;
    ctrl.clamp     = (state == S_CLAMP);
  end

  fess_datapath #(
    .ORDER_MAX (ORDER_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .coef        (coef_rd),
    .x_val       (x_rd),
    .input_level (input_level),
    .time_step   (time_step),
    .new_value   (new_value)
  );

  // Output register: the next report loads as soon as the slot is free.
  assign out_load = (state == S_REP_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index <= IDX_W'(i);
      out_value <= x_rd;
      out_step  <= step_count;
      out_last  <= last_i;
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_step, out_value, out_index};
  assign m_tlast = out_last;

endmodule
